>>> src/lkdsm_pkg.sv
// Package for the LED/key driver serial master.
// Holds the request and result payload types, the sequencer and frame stage
// enums, the command codes and the command byte constants. No dependencies.
package lkdsm_pkg;

  localparam int CLEAR_BYTES_DEF = 16;
  localparam int KEY_BYTES_DEF   = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_ON = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd1;

  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_INIT  = 3'd1;
  localparam logic [2:0] FUNC_SETUP = 3'd2;
  localparam logic [2:0] FUNC_WRITE = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  localparam logic [7:0] CMD_DATA_AUTO  = 8'h40;
  localparam logic [7:0] CMD_DATA_FIXED = 8'h44;
  localparam logic [7:0] CMD_DATA_READ  = 8'h42;
  localparam logic [7:0] CMD_ADDR       = 8'hC0;
  localparam logic [7:0] CMD_DISPLAY    = 8'h80;
  localparam logic [7:0] BYTE_CLEAR     = 8'h00;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_INIT0 = 4'd1,
    PH_INIT1 = 4'd2,
    PH_INIT2 = 4'd3,
    PH_SETUP = 4'd4,
    PH_WR0   = 4'd5,
    PH_WR1   = 4'd6,
    PH_RD    = 4'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_START = 2'd0,
    ST_BITS  = 2'd1,
    ST_END   = 2'd2
  } stage_t;

  typedef struct packed {
    logic [2:0] func;
    logic [3:0] addr;
    logic [7:0] data;
    logic       dio_in;
  } req_t;

  typedef struct packed {
    logic       stb;
    logic       clk_res;
    logic       dio_out;
    logic       dio_drive;
    logic       busy_res;
    logic [7:0] keys;
    logic       keys_valid;
  } res_t;

  typedef struct packed {
    logic stb;
    logic clk;
    logic dout;
    logic drive;
  } pins_t;

  // Byte to send for a frame; first selects the command byte of the frame.
  function automatic logic [7:0] frame_byte(input phase_t ph, input logic first,
                                            input logic [7:0] ctrl,
                                            input logic [3:0] addr,
                                            input logic [7:0] data);
    logic [7:0] b;
    b = BYTE_CLEAR;
    case (ph)
      PH_INIT0: b = CMD_DATA_AUTO;
      PH_INIT1: b = ctrl;
      PH_SETUP: b = ctrl;
      PH_INIT2: b = first ? CMD_ADDR : BYTE_CLEAR;
      PH_WR0:   b = CMD_DATA_FIXED;
      PH_WR1:   b = first ? (CMD_ADDR | {4'd0, addr}) : data;
      PH_RD:    b = first ? CMD_DATA_READ : BYTE_CLEAR;
      default:  b = BYTE_CLEAR;
    endcase
    return b;
  endfunction

endpackage

>>> src/led_key_driver_serial_master.sv
// An accepted request's result appears in the output register in the next cycle.
// Throughput: one request per cycle; the only stage is the sequencer state plus
// the output register, which keeps taking requests while a result waits unless stalled.
// Reset (synchronous, rst high): sequencer idle, strobe and clock high, data driven low,
// keys cleared, display_on 1, brightness 7, output register empty.
// Depends on lkdsm_pkg.
module led_key_driver_serial_master #(
  parameter int CLEAR_BYTES = lkdsm_pkg::CLEAR_BYTES_DEF,
  parameter int KEY_BYTES   = lkdsm_pkg::KEY_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  lkdsm_pkg::req_t                in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output lkdsm_pkg::res_t                out_data,
  input  logic                           cfg_we,
  input  logic [lkdsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lkdsm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic                display_on;
  logic [7:0]          brightness;

  lkdsm_pkg::phase_t   phase, phase_next;
  lkdsm_pkg::stage_t   stage, stage_next;
  logic [4:0]          byte_count, byte_count_next;
  logic [2:0]          bit_count, bit_count_next;
  logic                half_bit, half_bit_next;
  logic [7:0]          tx_shift, tx_shift_next;
  logic [7:0]          rx_shift, rx_shift_next;
  logic [7:0]          key_acc, key_acc_next;
  logic [7:0]          keys_held, keys_held_next;
  logic [3:0]          lat_addr, lat_addr_next;
  logic [7:0]          lat_data, lat_data_next;
  lkdsm_pkg::pins_t    pins, pins_next;

  logic                in_accept;
  logic                busy;
  logic                kvalid;
  logic                reading;
  logic [7:0]          ctrl_byte;
  logic [4:0]          frame_len;
  logic [4:0]          byte_inc;
  logic [2:0]          bit_inc;
  logic [2:0]          key_shift;
  logic [7:0]          rx_sampled;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign ctrl_byte = lkdsm_pkg::CMD_DISPLAY | {4'd0, display_on, 3'd0}
                   | {5'd0, (brightness > 8'd7) ? 3'd7 : brightness[2:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      display_on <= 1'b1;
      brightness <= 8'd7;
    end else if (cfg_we) begin
      case (cfg_index)
        lkdsm_pkg::CFG_DISPLAY_ON: display_on <= cfg_wdata[0];
        lkdsm_pkg::CFG_BRIGHTNESS: brightness <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next      = phase;
    lat_addr_next   = lat_addr;
    lat_data_next   = lat_data;
    key_acc_next    = key_acc;

    // A command starts only from idle; unused codes behave as a plain tick.
    if (phase == lkdsm_pkg::PH_IDLE) begin
      case (in_data.func)
        lkdsm_pkg::FUNC_INIT:  phase_next = lkdsm_pkg::PH_INIT0;
        lkdsm_pkg::FUNC_SETUP: phase_next = lkdsm_pkg::PH_SETUP;
        lkdsm_pkg::FUNC_WRITE: phase_next = lkdsm_pkg::PH_WR0;
        lkdsm_pkg::FUNC_READ:  phase_next = lkdsm_pkg::PH_RD;
        default:               phase_next = lkdsm_pkg::PH_IDLE;
      endcase
      if (phase_next != lkdsm_pkg::PH_IDLE) begin
        lat_addr_next = in_data.addr;
        lat_data_next = in_data.data;
      end
      if (phase_next == lkdsm_pkg::PH_RD) begin
        key_acc_next = 8'd0;
      end
    end

    case (phase_next)
      lkdsm_pkg::PH_INIT2: frame_len = 5'(CLEAR_BYTES + 1);
      lkdsm_pkg::PH_WR1:   frame_len = 5'd2;
      lkdsm_pkg::PH_RD:    frame_len = 5'(KEY_BYTES + 1);
      default:             frame_len = 5'd1;
    endcase

    reading    = (phase_next == lkdsm_pkg::PH_RD) && (byte_count != 5'd0);
    byte_inc   = byte_count + 5'd1;
    bit_inc    = bit_count + 3'd1;
    key_shift  = 3'(byte_count - 5'd1);
    rx_sampled = {in_data.dio_in, rx_shift[7:1]};

    stage_next      = stage;
    byte_count_next = byte_count;
    bit_count_next  = bit_count;
    half_bit_next   = half_bit;
    tx_shift_next   = tx_shift;
    rx_shift_next   = rx_shift;
    keys_held_next  = keys_held;
    pins_next       = pins;
    busy            = 1'b0;
    kvalid          = 1'b0;

    if (phase_next != lkdsm_pkg::PH_IDLE) begin
      busy = 1'b1;
      case (stage)
        lkdsm_pkg::ST_START: begin
          pins_next       = '{stb: 1'b0, clk: 1'b1, dout: pins.dout, drive: 1'b1};
          byte_count_next = 5'd0;
          bit_count_next  = 3'd0;
          half_bit_next   = 1'b0;
          tx_shift_next   = lkdsm_pkg::frame_byte(phase_next, 1'b1, ctrl_byte,
                                                  lat_addr_next, lat_data_next);
          rx_shift_next   = 8'd0;
          stage_next      = lkdsm_pkg::ST_BITS;
        end
        lkdsm_pkg::ST_BITS: begin
          if (!half_bit) begin
            if (reading) begin
              pins_next = '{stb: 1'b0, clk: 1'b0, dout: 1'b0, drive: 1'b0};
            end else begin
              pins_next = '{stb: 1'b0, clk: 1'b0, dout: tx_shift[0], drive: 1'b1};
            end
            half_bit_next = 1'b1;
          end else begin
            pins_next.clk  = 1'b1;
            half_bit_next  = 1'b0;
            bit_count_next = bit_inc;
            if (reading) begin
              rx_shift_next = rx_sampled;
            end else begin
              tx_shift_next = {1'b0, tx_shift[7:1]};
            end
            if (bit_inc == 3'd0) begin
              if (reading) begin
                key_acc_next = key_acc | (rx_sampled << key_shift);
              end
              byte_count_next = byte_inc;
              if (byte_inc >= frame_len) begin
                stage_next = lkdsm_pkg::ST_END;
              end else begin
                tx_shift_next = lkdsm_pkg::frame_byte(phase_next, 1'b0, ctrl_byte,
                                                      lat_addr_next, lat_data_next);
                rx_shift_next = 8'd0;
              end
            end
          end
        end
        default: begin
          // After a read the data line is driven low again.
          if (phase_next == lkdsm_pkg::PH_RD) begin
            pins_next      = '{stb: 1'b1, clk: 1'b1, dout: 1'b0, drive: 1'b1};
            keys_held_next = key_acc;
            kvalid         = 1'b1;
          end else begin
            pins_next = '{stb: 1'b1, clk: 1'b1, dout: pins.dout, drive: 1'b1};
          end
          stage_next = lkdsm_pkg::ST_START;
          case (phase_next)
            lkdsm_pkg::PH_INIT0: phase_next = lkdsm_pkg::PH_INIT1;
            lkdsm_pkg::PH_INIT1: phase_next = lkdsm_pkg::PH_INIT2;
            lkdsm_pkg::PH_WR0:   phase_next = lkdsm_pkg::PH_WR1;
            default:             phase_next = lkdsm_pkg::PH_IDLE;
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= lkdsm_pkg::PH_IDLE;
      stage      <= lkdsm_pkg::ST_START;
      byte_count <= 5'd0;
      bit_count  <= 3'd0;
      half_bit   <= 1'b0;
      tx_shift   <= 8'd0;
      rx_shift   <= 8'd0;
      key_acc    <= 8'd0;
      keys_held  <= 8'd0;
      lat_addr   <= 4'd0;
      lat_data   <= 8'd0;
      pins       <= '{stb: 1'b1, clk: 1'b1, dout: 1'b0, drive: 1'b1};
    end else if (in_accept) begin
      phase      <= phase_next;
      stage      <= stage_next;
      byte_count <= byte_count_next;
      bit_count  <= bit_count_next;
      half_bit   <= half_bit_next;
      tx_shift   <= tx_shift_next;
      rx_shift   <= rx_shift_next;
      key_acc    <= key_acc_next;
      keys_held  <= keys_held_next;
      lat_addr   <= lat_addr_next;
      lat_data   <= lat_data_next;
      pins       <= pins_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= '{stb: pins_next.stb, clk_res: pins_next.clk,
                    dio_out: pins_next.dout, dio_drive: pins_next.drive,
                    busy_res: busy, keys: keys_held_next, keys_valid: kvalid};
    end
  end

  // A completed key read always ends on a strobe-high tick with the data pin driven.
  a_keys_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.keys_valid |-> out_data.stb && out_data.dio_drive)
    else $error("key result without frame end");

  // Outside a command the strobe and clock rest high.
  a_idle_pins: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.busy_res |-> out_data.stb && out_data.clk_res)
    else $error("idle tick with strobe or clock low");

  // The data line is only released inside a command.
  a_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.dio_drive |-> out_data.busy_res && !out_data.stb)
    else $error("data line released outside a frame");

  // The sequencer always rests in the frame start stage.
  a_idle_stage: assert property (@(posedge clk) disable iff (rst)
    phase == lkdsm_pkg::PH_IDLE |-> stage == lkdsm_pkg::ST_START)
    else $error("idle sequencer not at frame start");

endmodule
